// ===== rtl/skrp_pkg.sv =====
// Shared types, codes and constants of the skyline rectangle packer.
// Used by skrp_cell and skyline_rect_packer_core; depends on nothing.
package skrp_pkg;

	localparam int DIM_W = 13;
	localparam int MAX_SEGMENTS_DEF = 64;
	localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;
	localparam logic [DIM_W-1:0] BIN_RESET = 13'd512;

	// input op codes
	localparam logic OP_PLACE = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// result status codes
	localparam logic [1:0] ST_PLACED  = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_CLEARED = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_BIN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_BIN_HEIGHT = 2'd1;

	typedef struct packed {
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
		logic [DIM_W-1:0] w;
	} seg_t;

	typedef struct packed {
		logic             busy;
		logic             ok;
		logic [DIM_W-1:0] y;
		logic [DIM_W-1:0] left;
	} cand_t;

	typedef enum logic [2:0] {
		CELL_HOLD     = 3'd0,
		CELL_CLEAR    = 3'd1,
		CELL_CAND_CLR = 3'd2,
		CELL_SEARCH   = 3'd3,
		CELL_ROTATE   = 3'd4,
		CELL_INSERT   = 3'd5,
		CELL_REMOVE   = 3'd6,
		CELL_MERGE    = 3'd7
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [DIM_W-1:0] rect_w;
		logic [DIM_W-1:0] rect_h;
		logic [DIM_W-1:0] bin_w;
		logic [DIM_W-1:0] bin_h;
		logic             head_valid;
		logic             last;
		seg_t             ns;
		logic [DIM_W:0]   right_edge;
	} cell_ctrl_t;

endpackage

// ===== rtl/skrp_cell.sv =====
// One skyline cell: holds one segment, its fit candidate and a drop mark.
// Depends on skrp_pkg; instantiated in a ring by skyline_rect_packer_core.
module skrp_cell #(
	parameter int MAX_SEGMENTS = skrp_pkg::MAX_SEGMENTS_DEF,
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  skrp_pkg::cell_ctrl_t              ctrl,
	input  logic [$clog2(MAX_SEGMENTS)-1:0]   k,
	input  logic [$clog2(MAX_SEGMENTS+1)-1:0] count,
	input  skrp_pkg::seg_t                    head,
	input  skrp_pkg::seg_t                    left_seg,
	input  skrp_pkg::seg_t                    right_seg,
	input  skrp_pkg::cand_t                   right_cand,
	input  logic                              right_dead,
	input  logic                              dead_below_in,
	input  logic                              eq_below_in,
	output skrp_pkg::seg_t                    seg,
	output skrp_pkg::cand_t                   cand,
	output logic                              dead,
	output logic                              dead_below_out,
	output logic                              eq_below_out
);
	localparam int CW = $clog2(MAX_SEGMENTS+1);
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam logic [CW:0] IDX_C = (CW+1)'(IDX);
	localparam logic [CW:0] IDX_N = (CW+1)'(IDX+1);
	localparam logic [IW-1:0] IDX_K = IW'(IDX);
	localparam logic IS_TAIL = (IDX == MAX_SEGMENTS-1);
	// cell zero starts as the full floor, the rest empty
	localparam skrp_pkg::seg_t SEG_RESET = '{
		x: '0,
		y: '0,
		w: (IDX == 0) ? skrp_pkg::BIN_RESET : skrp_pkg::DIM_W'(0)
	};

	skrp_pkg::seg_t  seg_q, seg_d;
	skrp_pkg::cand_t cand_q, cand_d, c_in;
	logic dead_q, dead_d;
	logic valid, valid_nx, dead_eff, eq;
	logic start, xfail, topfail, ovl, drop;
	logic [skrp_pkg::DIM_W-1:0] ny;
	logic [skrp_pkg::DIM_W:0] l_end;

	assign valid    = IDX_C < {1'b0, count};
	assign valid_nx = IDX_N < {1'b0, count};
	assign dead_eff = dead_q & valid;
	assign eq       = valid_nx && (seg_q.y == right_seg.y);
	assign dead_below_out = dead_below_in | dead_eff;
	assign eq_below_out   = eq_below_in | eq;

	always_comb begin
		// fit step for the candidate that arrives from the right neighbor
		start = IS_TAIL && ctrl.head_valid;
		c_in = right_cand;
		if (start) begin
			c_in = '{busy: 1'b1, ok: 1'b0, y: head.y, left: ctrl.rect_w};
		end
		ny = (head.y > c_in.y) ? head.y : c_in.y;
		xfail = start && (({1'b0, head.x} + {1'b0, ctrl.rect_w}) > {1'b0, ctrl.bin_w});
		topfail = ({1'b0, ny} + {1'b0, ctrl.rect_h}) > {1'b0, ctrl.bin_h};
		// trim of the left neighbor when it lands under the new segment
		l_end = {1'b0, left_seg.x} + {1'b0, left_seg.w};
		ovl = {1'b0, left_seg.x} < ctrl.right_edge;
		drop = ovl && (l_end <= ctrl.right_edge);

		seg_d = seg_q;
		cand_d = cand_q;
		dead_d = dead_q;
		case (ctrl.op)
			skrp_pkg::CELL_CLEAR: begin
				seg_d = '0;
				if (IDX == 0) seg_d.w = ctrl.bin_w;
				dead_d = 1'b0;
			end
			skrp_pkg::CELL_CAND_CLR: begin
				cand_d = '0;
			end
			skrp_pkg::CELL_SEARCH: begin
				seg_d = right_seg;
				dead_d = right_dead;
				cand_d = c_in;
				if (ctrl.head_valid && c_in.busy) begin
					if (xfail || topfail) begin
						cand_d.busy = 1'b0;
						cand_d.ok = 1'b0;
					end else if (head.w >= c_in.left) begin
						cand_d.busy = 1'b0;
						cand_d.ok = 1'b1;
						cand_d.y = ny;
					end else if (ctrl.last) begin
						cand_d.busy = 1'b0;
						cand_d.ok = 1'b0;
					end else begin
						cand_d.left = c_in.left - head.w;
						cand_d.y = ny;
					end
				end
			end
			skrp_pkg::CELL_ROTATE: begin
				seg_d = right_seg;
				cand_d = right_cand;
				dead_d = right_dead;
			end
			skrp_pkg::CELL_INSERT: begin
				if (IDX_K == k) begin
					seg_d = ctrl.ns;
					dead_d = 1'b0;
				end else if (IDX_K > k) begin
					seg_d = left_seg;
					dead_d = drop;
					if (ovl && !drop) begin
						seg_d.x = ctrl.right_edge[skrp_pkg::DIM_W-1:0];
						seg_d.w = skrp_pkg::DIM_W'(l_end - ctrl.right_edge);
					end
				end else begin
					dead_d = 1'b0;
				end
			end
			skrp_pkg::CELL_REMOVE: begin
				if (dead_below_in || dead_eff) begin
					seg_d = right_seg;
					dead_d = right_dead;
				end
			end
			skrp_pkg::CELL_MERGE: begin
				if (eq_below_in) begin
					seg_d = right_seg;
					dead_d = right_dead;
				end else if (eq) begin
					seg_d.w = seg_q.w + right_seg.w;
				end
			end
			default: begin
				seg_d = seg_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_RESET;
			cand_q <= '0;
			dead_q <= 1'b0;
		end else begin
			seg_q <= seg_d;
			cand_q <= cand_d;
			dead_q <= dead_d;
		end
	end

	assign seg  = seg_q;
	assign cand = cand_q;
	assign dead = dead_q;

endmodule

// ===== rtl/skyline_rect_packer_core.sv =====
// Skyline rectangle packer: top level with sequencer, result register and cell ring.
// Depends on skrp_pkg and skrp_cell.
// Sequence: a clear or oversize request goes straight to the response; a place runs two full
// turns of the cell ring (search, select), a decide step, then edit steps that drop or merge segments.
// Throughput: one item at a time; a new request is taken only once the sequencer is back in idle.
// Reset: asynchronous, skyline holds one floor segment 512 wide, both bin registers 512.
module skyline_rect_packer_core #(
	parameter int MAX_SEGMENTS = skrp_pkg::MAX_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [11:0] rect_width,
	input  logic [11:0] rect_height,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [11:0] pos_x,
	output logic [11:0] pos_y,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	localparam int CW = $clog2(MAX_SEGMENTS+1);
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int DW = skrp_pkg::DIM_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SEARCH = 6'b000010,
		S_SELECT = 6'b000100,
		S_DECIDE = 6'b001000,
		S_EDIT   = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t state_q;

	logic [DW-1:0] bin_w_q, bin_h_q, cfg_sat;
	logic [DW-1:0] rect_w_q, rect_h_q, w_in, h_in;
	logic [IW-1:0] t_q, k_q;
	logic [CW-1:0] count_q;
	logic          found_q;
	logic [DW-1:0] best_x_q, best_y_q, best_w_q;
	logic [1:0]    res_status_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [11:0]   pos_x_q, pos_y_q;

	logic in_acc, out_free, t_last, full, better;
	skrp_pkg::cell_ctrl_t ctrl;

	skrp_pkg::seg_t  seg_w  [MAX_SEGMENTS];
	skrp_pkg::cand_t cand_w [MAX_SEGMENTS];
	logic            dead_w [MAX_SEGMENTS];
	logic [MAX_SEGMENTS:0] dead_chain, eq_chain;

	// Configuration: always ready, saturate to the largest bin.
	assign cfg_ready = 1'b1;
	assign cfg_sat = (cfg_data > skrp_pkg::DIM_MAX) ? skrp_pkg::DIM_MAX : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_w_q <= skrp_pkg::BIN_RESET;
			bin_h_q <= skrp_pkg::BIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == skrp_pkg::REG_BIN_WIDTH) bin_w_q <= cfg_sat;
			if (cfg_index == skrp_pkg::REG_BIN_HEIGHT) bin_h_q <= cfg_sat;
		end
	end

	// Request side: take a beat only when the sequencer is idle; the result
	// register decouples the next request from a result still waiting.
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Padded size of the incoming request.
	assign w_in = {1'b0, rect_width} + DW'(1);
	assign h_in = {1'b0, rect_height} + DW'(1);

	assign t_last = (t_q == IW'(MAX_SEGMENTS-1));
	assign full   = (count_q == CW'(MAX_SEGMENTS));

	// Head of the ring is segment t during both turns; keep the lowest top,
	// then the narrower segment, then the first one.
	assign better = (CW'(t_q) < count_q) && cand_w[0].ok &&
		(!found_q || (cand_w[0].y < best_y_q) ||
		 ((cand_w[0].y == best_y_q) && (seg_w[0].w < best_w_q)));

	// Cell control: one command for the whole ring each cycle.
	always_comb begin
		ctrl.op         = skrp_pkg::CELL_HOLD;
		ctrl.rect_w     = rect_w_q;
		ctrl.rect_h     = rect_h_q;
		ctrl.bin_w      = bin_w_q;
		ctrl.bin_h      = bin_h_q;
		ctrl.head_valid = CW'(t_q) < count_q;
		ctrl.last       = (CW'(t_q) + CW'(1)) >= count_q;
		ctrl.ns.x       = best_x_q;
		ctrl.ns.y       = best_y_q + rect_h_q;
		ctrl.ns.w       = rect_w_q;
		ctrl.right_edge = {1'b0, best_x_q} + {1'b0, rect_w_q};
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (op == skrp_pkg::OP_CLEAR) begin
						ctrl.op = skrp_pkg::CELL_CLEAR;
					end else begin
						ctrl.op = skrp_pkg::CELL_CAND_CLR;
					end
				end
			end
			S_SEARCH: ctrl.op = skrp_pkg::CELL_SEARCH;
			S_SELECT: ctrl.op = skrp_pkg::CELL_ROTATE;
			S_DECIDE: begin
				if (found_q && !full) ctrl.op = skrp_pkg::CELL_INSERT;
			end
			S_EDIT: begin
				if (dead_chain[MAX_SEGMENTS]) begin
					ctrl.op = skrp_pkg::CELL_REMOVE;
				end else if (eq_chain[MAX_SEGMENTS]) begin
					ctrl.op = skrp_pkg::CELL_MERGE;
				end
			end
			default: ctrl.op = skrp_pkg::CELL_HOLD;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			t_q          <= '0;
			count_q      <= CW'(1);
			found_q      <= 1'b0;
			res_status_q <= skrp_pkg::ST_PLACED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						t_q <= '0;
						found_q <= 1'b0;
						if (op == skrp_pkg::OP_CLEAR) begin
							count_q <= CW'(1);
							res_status_q <= skrp_pkg::ST_CLEARED;
							state_q <= S_RESP;
						end else if (w_in > bin_w_q || h_in > bin_h_q) begin
							res_status_q <= skrp_pkg::ST_NOFIT;
							state_q <= S_RESP;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (t_last) begin
						t_q <= '0;
						state_q <= S_SELECT;
					end else begin
						t_q <= t_q + IW'(1);
					end
				end
				S_SELECT: begin
					if (better) found_q <= 1'b1;
					if (t_last) begin
						t_q <= '0;
						state_q <= S_DECIDE;
					end else begin
						t_q <= t_q + IW'(1);
					end
				end
				S_DECIDE: begin
					if (!found_q) begin
						res_status_q <= skrp_pkg::ST_NOFIT;
						state_q <= S_RESP;
					end else if (full) begin
						res_status_q <= skrp_pkg::ST_FULL;
						state_q <= S_RESP;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_EDIT;
					end
				end
				S_EDIT: begin
					if (dead_chain[MAX_SEGMENTS] || eq_chain[MAX_SEGMENTS]) begin
						count_q <= count_q - CW'(1);
					end else begin
						res_status_q <= skrp_pkg::ST_PLACED;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request size and best candidate, payload only.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rect_w_q <= w_in;
			rect_h_q <= h_in;
		end
		if (state_q == S_SELECT && better) begin
			k_q      <= t_q;
			best_x_q <= seg_w[0].x;
			best_y_q <= cand_w[0].y;
			best_w_q <= seg_w[0].w;
		end
	end

	// Result register: load in RESP once the previous beat has gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			status_q <= res_status_q;
			pos_x_q  <= (res_status_q == skrp_pkg::ST_PLACED) ? best_x_q[11:0] : 12'd0;
			pos_y_q  <= (res_status_q == skrp_pkg::ST_PLACED) ? best_y_q[11:0] : 12'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;

	// Cell ring: each cell sees both neighbors; the last wraps to the head.
	assign dead_chain[0] = 1'b0;
	assign eq_chain[0]   = 1'b0;

	for (genvar j = 0; j < MAX_SEGMENTS; j++) begin : g_cell
		skrp_cell #(
			.MAX_SEGMENTS(MAX_SEGMENTS),
			.IDX(j)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.k             (k_q),
			.count         (count_q),
			.head          (seg_w[0]),
			.left_seg      (seg_w[(j + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
			.right_seg     (seg_w[(j + 1) % MAX_SEGMENTS]),
			.right_cand    (cand_w[(j + 1) % MAX_SEGMENTS]),
			.right_dead    (dead_w[(j + 1) % MAX_SEGMENTS]),
			.dead_below_in (dead_chain[j]),
			.eq_below_in   (eq_chain[j]),
			.seg           (seg_w[j]),
			.cand          (cand_w[j]),
			.dead          (dead_w[j]),
			.dead_below_out(dead_chain[j+1]),
			.eq_below_out  (eq_chain[j+1])
		);
	end

	// Segment count stays within the store.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CW'(MAX_SEGMENTS)))
		else $error("segment count out of range");

	// An insert grows the skyline by exactly one segment.
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && found_q && !full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the skyline");

	// A new result beat only comes out of the response state.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result beat without response state");

	// The sequencer leaves idle only on an accepted request.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !in_valid) |=> (state_q == S_IDLE))
		else $error("sequencer left idle without a request");

endmodule
